>>> src/hnc_pkg.sv
// Shared constants and the 64-bit population count for the nearest-centroid search.
`default_nettype none
package hnc_pkg;

  localparam int MAX_CENTROIDS_DEF = 16;
  localparam int DESC_WORDS_DEF    = 4;

  localparam int WORD_W  = 64;
  localparam int DIST_W  = 9;
  localparam int PC_W    = 7;
  localparam int COUNT_W = 5;
  localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // Count set bits: pair, nibble and byte sums, then add the eight bytes
  function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [PC_W-1:0]   s;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + PC_W'(c[i*8 +: 4]);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> src/hamming_nearest_centroid.sv
// Top level: centroid store, running distances and the nearest-centroid search.
//
// Usage:
//   Input channel (in_valid/in_stall) carries load items (operation 0), which
//   write one 64-bit centroid word, and point items (operation 1), which give one
//   word of a feature point. A load is stored on acceptance and never stalls the input.
//   A point word is compared against every active centroid, one centroid per
//   cycle, through a three-stage read/popcount/accumulate pipeline around the
//   centroid memory and the running-distance memory. After a point item is
//   accepted, in_stall stays high through the search and the final step (only
//   the final step with no centroids); active is centroid_count capped at MAX_CENTROIDS.
//   On the last word of a point that is not itself a centroid one result item
//   is loaded into the output register (out_valid/out_stall) in the final cycle.
//   If an earlier result is still stalled there, the block holds the new one
//   and keeps in_stall high until the output register frees up.
//   cfg_write_en/cfg_write_data set centroid_count; write only while idle.
//   Reset clears the count, the control state and the running distances
//   (through per-slot valid bits); centroid words are undefined until loaded.
`default_nettype none
module hamming_nearest_centroid #(
  parameter int MAX_CENTROIDS = hnc_pkg::MAX_CENTROIDS_DEF,
  parameter int DESC_WORDS    = hnc_pkg::DESC_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_write_en,
  input  wire logic [hnc_pkg::COUNT_W-1:0] cfg_write_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_operation,
  input  wire logic [3:0]                  in_slot,
  input  wire logic [1:0]                  in_word_index,
  input  wire logic [hnc_pkg::WORD_W-1:0]  in_word_value,
  input  wire logic [15:0]                 in_point_id,
  input  wire logic                        in_is_centroid,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [3:0]                       out_nearest_centroid,
  output logic [hnc_pkg::DIST_W-1:0]       out_best_distance,
  output logic [15:0]                      out_point_tag,
  output logic                             out_no_centroids
);

  localparam int SLOT_W  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int CNT_W   = $clog2(MAX_CENTROIDS + 1);
  localparam int DEPTH   = MAX_CENTROIDS * DESC_WORDS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W  = hnc_pkg::WORD_W;
  localparam int DIST_W  = hnc_pkg::DIST_W;
  localparam int PC_W    = hnc_pkg::PC_W;

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  // Memories
  logic [WORD_W-1:0] cmem [DEPTH];
  logic [DIST_W-1:0] pmem [MAX_CENTROIDS];

  // Control and item registers
  state_t                    state_r;
  logic [hnc_pkg::COUNT_W-1:0] count_r;
  logic [CNT_W-1:0]          active;
  logic [CNT_W-1:0]          iss_r;
  logic [ADDR_W-1:0]         caddr_r;
  logic [WORD_W-1:0]         word_r;
  logic                      first_r;
  logic                      last_r;
  logic                      iscent_r;
  logic [15:0]               tag_r;
  logic [MAX_CENTROIDS-1:0]  pvalid_r;

  // Pipeline registers
  logic                      v1_r;
  logic [SLOT_W-1:0]         c1_r;
  logic [WORD_W-1:0]         cdata_r;
  logic [DIST_W-1:0]         pdata_r;
  logic                      pv1_r;
  logic                      v2_r;
  logic [SLOT_W-1:0]         c2_r;
  logic [PC_W-1:0]           pc2_r;
  logic [DIST_W-1:0]         base2_r;

  // Search result
  logic                      found_r;
  logic [SLOT_W-1:0]         best_slot_r;
  logic [DIST_W-1:0]         best_dist_r;

  // Output register
  logic                      out_valid_r;
  logic [3:0]                out_nc_r;
  logic [DIST_W-1:0]         out_dist_r;
  logic [15:0]               out_tag_r;
  logic                      out_none_r;

  logic                      acc;
  logic                      widx_ok;
  logic                      slot_ok;
  logic                      load_we;
  logic [ADDR_W-1:0]         load_addr;
  logic                      issue;
  logic [SLOT_W-1:0]         iss_idx;
  logic [DIST_W:0]           sum;
  logic [DIST_W-1:0]         sat;
  logic                      s2_last;
  logic                      need_result;
  logic                      out_free;
  logic                      out_load;

  // Cap the configured count at the slot total
  assign active = (32'(count_r) > MAX_CENTROIDS) ? CNT_W'(MAX_CENTROIDS) : CNT_W'(count_r);

  // Accept and decode the input item
  assign in_stall  = (state_r != IDLE);
  assign acc       = in_valid && !in_stall;
  assign widx_ok   = (32'(in_word_index) < DESC_WORDS);
  assign slot_ok   = (32'(in_slot) < MAX_CENTROIDS);
  assign load_we   = acc && (in_operation == hnc_pkg::OP_LOAD) && widx_ok && slot_ok;
  assign load_addr = ADDR_W'(32'(in_slot) * DESC_WORDS + 32'(in_word_index));

  // Issue one centroid read per cycle
  assign issue   = (state_r == RUN) && (iss_r < active);
  assign iss_idx = iss_r[SLOT_W-1:0];

  // Accumulate with saturation
  assign sum     = {1'b0, base2_r} + (DIST_W + 1)'(pc2_r);
  assign sat     = sum[DIST_W] ? hnc_pkg::DIST_MAX : sum[DIST_W-1:0];
  assign s2_last = v2_r && (c2_r == SLOT_W'(active - CNT_W'(1)));

  assign need_result = last_r && !iscent_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign out_load    = (state_r == FINISH) && need_result && out_free;

  // Centroid store: write on load, read during the search
  always_ff @(posedge clk) begin
    if (load_we) begin
      cmem[load_addr] <= in_word_value;
    end
    if (issue) begin
      cdata_r <= cmem[caddr_r];
    end
  end

  // Running distances: read at issue, write back at the accumulate stage
  always_ff @(posedge clk) begin
    if (v2_r) begin
      pmem[c2_r] <= sat;
    end
    if (issue) begin
      pdata_r <= pmem[iss_idx];
    end
  end

  // Payload pipeline registers
  always_ff @(posedge clk) begin
    if (issue) begin
      c1_r  <= iss_idx;
    end
    if (v1_r) begin
      c2_r    <= c1_r;
      pc2_r   <= hnc_pkg::popcount64(cdata_r ^ word_r);
      base2_r <= (first_r || !pv1_r) ? '0 : pdata_r;
    end
  end

  // State machine, pipeline control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      iss_r       <= '0;
      pvalid_r    <= '0;
      v1_r        <= 1'b0;
      pv1_r       <= 1'b0;
      v2_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        count_r <= cfg_write_data;
      end

      // Drop a result once it is taken, unless a new one replaces it
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      // Advance the pipeline
      v1_r  <= issue;
      pv1_r <= issue ? pvalid_r[iss_idx] : 1'b0;
      v2_r  <= v1_r;
      if (issue) begin
        iss_r   <= iss_r + CNT_W'(1);
        caddr_r <= caddr_r + ADDR_W'(DESC_WORDS);
      end
      if (v2_r) begin
        pvalid_r[c2_r] <= 1'b1;
        if (!found_r || (sat < best_dist_r)) begin
          found_r     <= 1'b1;
          best_slot_r <= c2_r;
          best_dist_r <= sat;
        end
      end

      case (state_r)
        IDLE: begin
          if (acc && (in_operation == hnc_pkg::OP_POINT) && widx_ok) begin
            word_r      <= in_word_value;
            first_r     <= (in_word_index == 2'd0);
            last_r      <= (32'(in_word_index) == DESC_WORDS - 1);
            iscent_r    <= in_is_centroid;
            tag_r       <= in_point_id;
            iss_r       <= '0;
            caddr_r     <= ADDR_W'(in_word_index);
            found_r     <= 1'b0;
            best_slot_r <= '0;
            best_dist_r <= '0;
            state_r     <= (active == '0) ? FINISH : RUN;
          end
        end
        RUN: begin
          if (s2_last) begin
            state_r <= FINISH;
          end
        end
        FINISH: begin
          if (!need_result) begin
            state_r <= IDLE;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            out_nc_r    <= 4'(best_slot_r);
            out_dist_r  <= best_dist_r;
            out_tag_r   <= tag_r;
            out_none_r  <= !found_r;
            state_r     <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_centroid = out_nc_r;
  assign out_best_distance    = out_dist_r;
  assign out_point_tag        = out_tag_r;
  assign out_no_centroids     = out_none_r;

  // Issue count never runs past the active slots
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RUN) |-> (iss_r <= active))
    else $error("issue counter past active slots");

  // Pipeline stages only carry work while searching
  a_pipe_run: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> (state_r == RUN))
    else $error("pipeline active outside search");

  // A new result comes only from the final step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == FINISH))
    else $error("result loaded outside final step");

  // An empty search reports slot zero at distance zero
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_none_r) |-> (out_dist_r == '0 && out_nc_r == 4'd0))
    else $error("empty search with nonzero result");

endmodule
`default_nettype wire
